[src/lph_pkg.sv]
// Shared types and constants for the linear probe hash table.
// Used by lph_mod, linear_probe_hash_table and the testbench; depends on nothing.
package lph_pkg;

   localparam int unsigned KEY_WIDTH           = 31;
   localparam int unsigned OP_WIDTH            = 2;
   localparam int unsigned STATUS_WIDTH        = 2;
   localparam int unsigned SLOT_WIDTH          = 10;
   localparam int unsigned CFG_WIDTH           = 11;
   localparam int unsigned TABLE_DEPTH_DEFAULT = 1024;

   localparam logic [CFG_WIDTH-1:0] CFG_RESET = CFG_WIDTH'(1024);

   localparam logic [OP_WIDTH-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_WIDTH-1:0] OP_DELETE = 2'd1;
   localparam logic [OP_WIDTH-1:0] OP_SEARCH = 2'd2;

   localparam logic [STATUS_WIDTH-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_MISSING = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_FULL    = 2'd2;
   localparam logic [STATUS_WIDTH-1:0] STATUS_PRESENT = 2'd3;

   typedef struct packed {
      logic [OP_WIDTH-1:0]  op;
      logic [KEY_WIDTH-1:0] key;
   } req_type;

   typedef struct packed {
      logic [STATUS_WIDTH-1:0] status;
      logic [SLOT_WIDTH-1:0]   slot;
   } rsp_type;

endpackage

[src/lph_mod.sv]
// Bit-serial remainder unit: key modulo the live table size, one bit a cycle.
// Depends on lph_pkg.
module lph_mod #(
   parameter int unsigned TABLE_DEPTH = lph_pkg::TABLE_DEPTH_DEFAULT,
   localparam int unsigned NW = $clog2(TABLE_DEPTH + 1),
   localparam int unsigned AW = $clog2(TABLE_DEPTH)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [lph_pkg::KEY_WIDTH-1:0]  dividend,
   input  logic [NW-1:0]                  divisor,
   output logic                           done,
   output logic [AW-1:0]                  remainder
);
   import lph_pkg::*;

   localparam int unsigned CW = $clog2(KEY_WIDTH);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [KEY_WIDTH-1:0] dvd_ff, dvd_in;
   logic [NW-1:0]        rem_ff, rem_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [NW:0]          shifted;
   logic [NW:0]          diff;

   assign shifted = {rem_ff, dvd_ff[KEY_WIDTH-1]};
   assign diff    = shifted - {1'b0, divisor};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         busy_in = 1'b1;
         dvd_in  = dividend;
         rem_in  = '0;
         cnt_in  = CW'(KEY_WIDTH - 1);
      end else if (busy_ff) begin
         dvd_in = dvd_ff << 1;
         rem_in = (shifted >= {1'b0, divisor}) ? diff[NW-1:0] : shifted[NW-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff[AW-1:0];

endmodule

[src/linear_probe_hash_table.sv]
// Top level of the linear probe hash table: sequencer, slot store and result register.
// Depends on lph_pkg and lph_mod.
//
// Open-addressing key table with linear probing. Each request word inserts, deletes or
// searches a 31-bit key (any other op is answered missing); the home slot is key modulo
// csr table_size (clamped to 1..TABLE_DEPTH), and probing walks forward with wrap until a
// free slot, the key or a full lap. After reset the slot store is swept clear, one slot a
// cycle, before the first request word is taken. One word is worked at a time: accept,
// the bit-serial modulo unit, a read state and a check state per slot probed through the
// single-port slot store, then hand over the response once the response register is free.
// A finished response waits in its own register while the next request word is accepted.
module linear_probe_hash_table #(
   parameter int unsigned TABLE_DEPTH = lph_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  lph_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output lph_pkg::rsp_type              rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [lph_pkg::CFG_WIDTH-1:0] csr_data
);
   import lph_pkg::*;

   localparam int unsigned NW = $clog2(TABLE_DEPTH + 1);
   localparam int unsigned AW = $clog2(TABLE_DEPTH);
   localparam int unsigned WW = KEY_WIDTH + 1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV,
      ST_READ,
      ST_CHECK,
      ST_FINISH
   } state_type;

   state_type            state_ff, state_in;
   logic [AW-1:0]        clr_ff, clr_in;
   logic [OP_WIDTH-1:0]  op_ff, op_in;
   logic [KEY_WIDTH-1:0] key_ff, key_in;
   logic [NW-1:0]        n_ff, n_in;
   logic [AW-1:0]        j_ff, j_in;
   logic [NW-1:0]        count_ff, count_in;
   rsp_type              res_ff, res_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;
   logic [CFG_WIDTH-1:0] table_size_ff, table_size_in;

   logic [WW-1:0]        mem [TABLE_DEPTH];
   logic [WW-1:0]        rd_ff;
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [WW-1:0]        wr_data;

   logic [31:0]          cfg_wide;
   logic [NW-1:0]        live_n;
   logic                 div_start;
   logic                 div_done;
   logic [AW-1:0]        div_rem;
   logic                 rd_used;
   logic                 stop;
   logic                 lap_end;
   logic [AW-1:0]        j_next;
   logic [SLOT_WIDTH-1:0] slot_of_j;

   lph_mod #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (req_data.key),
      .divisor   (n_ff),
      .done      (div_done),
      .remainder (div_rem)
   );

   assign cfg_wide = 32'(table_size_ff);
   assign live_n   = (cfg_wide == 32'd0) ? NW'(1) :
                     (cfg_wide > 32'(TABLE_DEPTH)) ? NW'(TABLE_DEPTH) : NW'(cfg_wide);

   assign rd_used   = rd_ff[KEY_WIDTH];
   assign stop      = !rd_used || (rd_ff[KEY_WIDTH-1:0] == key_ff);
   assign lap_end   = (count_ff + 1'b1) == n_ff;
   assign j_next    = ((NW'(j_ff) + 1'b1) == n_ff) ? '0 : j_ff + 1'b1;
   assign slot_of_j = SLOT_WIDTH'(32'(j_ff));

   always_comb begin
      div_start = 1'b0;
      if (state_ff == ST_IDLE && req_valid) begin
         case (req_data.op) inside
            OP_INSERT, OP_DELETE, OP_SEARCH: div_start = 1'b1;
            default:                         div_start = 1'b0;
         endcase
      end
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = j_ff;
      wr_data = '0;
      if (state_ff == ST_CLEAR) begin
         wr_en   = 1'b1;
         wr_addr = clr_ff;
      end else if (state_ff == ST_CHECK && stop) begin
         if (op_ff == OP_INSERT && !rd_used) begin
            wr_en   = 1'b1;
            wr_data = {1'b1, key_ff};
         end else if (op_ff == OP_DELETE && rd_used) begin
            wr_en = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[j_ff];
   end

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      n_in          = n_ff;
      j_in          = j_ff;
      count_in      = count_ff;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      table_size_in = table_size_ff;

      if (csr_valid) begin
         table_size_in = csr_data;
      end
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == AW'(TABLE_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               op_in  = req_data.op;
               key_in = req_data.key;
               n_in   = live_n;
               if (div_start) begin
                  state_in = ST_DIV;
               end else begin
                  res_in.status = STATUS_MISSING;
                  res_in.slot   = '0;
                  state_in      = ST_FINISH;
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               j_in     = div_rem;
               count_in = '0;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (stop) begin
               if (op_ff == OP_INSERT) begin
                  res_in.status = rd_used ? STATUS_PRESENT : STATUS_OK;
                  res_in.slot   = slot_of_j;
               end else begin
                  res_in.status = rd_used ? STATUS_OK : STATUS_MISSING;
                  res_in.slot   = rd_used ? slot_of_j : '0;
               end
               state_in = ST_FINISH;
            end else if (lap_end) begin
               res_in.status = (op_ff == OP_INSERT) ? STATUS_FULL : STATUS_MISSING;
               res_in.slot   = '0;
               state_in      = ST_FINISH;
            end else begin
               j_in     = j_next;
               count_in = count_ff + 1'b1;
               state_in = ST_READ;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_data_in  = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         table_size_ff <= CFG_RESET;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         op_ff         <= op_in;
         key_ff        <= key_in;
         n_ff          <= n_in;
         j_ff          <= j_in;
         count_ff      <= count_in;
         res_ff        <= res_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_data_ff   <= rsp_data_in;
         table_size_ff <= table_size_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

   a_probe_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ || state_ff == ST_CHECK) |->
         (NW'(j_ff) < n_ff && count_ff < n_ff))
      else $error("probe index or count beyond live table size");

   a_home_in_range: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (NW'(div_rem) < n_ff))
      else $error("home slot not below live table size");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_FINISH))
      else $error("response raised outside finish state");

endmodule

[sim/tb_linear_probe_hash_table.sv]
// Self-checking testbench for linear_probe_hash_table: directed and random insert, delete
// and search words against a local table model, under random sender bursts and stalls.
// Depends on lph_pkg and linear_probe_hash_table.
module tb_linear_probe_hash_table;
   import lph_pkg::*;

   localparam int unsigned TABLE_DEPTH = TABLE_DEPTH_DEFAULT;
   localparam logic [OP_WIDTH-1:0] OP_UNUSED = 2'd3;
   localparam int unsigned TIMEOUT_CYCLES = 3_000_000;
   localparam int unsigned DRAIN_CYCLES = 200;
   localparam int unsigned PHASE_WORDS = 130;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CFG_WIDTH-1:0] csr_data = '0;

   req_type pending_req[$];
   rsp_type expected_rsp[$];
   rsp_type want;
   int unsigned words_queued = 0;
   int unsigned words_taken = 0;
   int unsigned mismatch_count = 0;
   logic req_taken = 1'b0;
   int unsigned burst_left = 0;
   int unsigned gap_left = 0;
   int unsigned stall_left = 0;
   int unsigned open_left = 0;

   logic [CFG_WIDTH-1:0] size_cfg;
   logic [KEY_WIDTH-1:0] slot_key [TABLE_DEPTH];
   logic slot_free [TABLE_DEPTH];

   logic [KEY_WIDTH-1:0] key_pool[$];
   logic [KEY_WIDTH-1:0] key_history[$];

   linear_probe_hash_table #(.TABLE_DEPTH(TABLE_DEPTH)) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data)
   );

   always #6 clock = ~clock;

   function automatic int unsigned clamp_size(input int unsigned v);
      if (v < 1) return 1;
      if (v > TABLE_DEPTH) return TABLE_DEPTH;
      return v;
   endfunction

   function automatic rsp_type apply_table_op(input req_type r);
      int unsigned span;
      int unsigned at;
      bit hit;
      rsp_type res;
      span = clamp_size(size_cfg);
      at = r.key % span;
      hit = 1'b0;
      for (int n = 0; n < span; n++) begin
         if (slot_free[at] || slot_key[at] == r.key) begin
            hit = 1'b1;
            break;
         end
         at = (at + 1 == span) ? 0 : at + 1;
      end
      res.status = STATUS_MISSING;
      res.slot = '0;
      case (r.op)
         OP_INSERT: begin
            if (!hit) begin
               res.status = STATUS_FULL;
            end else if (slot_free[at]) begin
               slot_free[at] = 1'b0;
               slot_key[at] = r.key;
               res.status = STATUS_OK;
               res.slot = SLOT_WIDTH'(at);
            end else begin
               res.status = STATUS_PRESENT;
               res.slot = SLOT_WIDTH'(at);
            end
         end
         OP_DELETE, OP_SEARCH: begin
            if (hit && !slot_free[at]) begin
               if (r.op == OP_DELETE) slot_free[at] = 1'b1;
               res.status = STATUS_OK;
               res.slot = SLOT_WIDTH'(at);
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("%0t: %s", $time, msg);
   endtask

   // sample handshakes, predict on each accepted request, check each accepted response
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
         size_cfg = CFG_RESET;
         foreach (slot_free[i]) slot_free[i] = 1'b1;
         foreach (slot_key[i]) slot_key[i] = '0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (csr_valid && csr_ready) size_cfg = csr_data;
         if (req_valid && !req_stall) begin
            expected_rsp.push_back(apply_table_op(req_data));
            words_taken++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
               report_mismatch($sformatf("response word with none expected: status %0d slot %0d",
                  rsp_data.status, rsp_data.slot));
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_data.status !== want.status)
                  report_mismatch($sformatf("status mismatch: got %0d, want %0d",
                     rsp_data.status, want.status));
               if (rsp_data.slot !== want.slot)
                  report_mismatch($sformatf("slot mismatch: got %0d, want %0d",
                     rsp_data.slot, want.slot));
            end
         end
      end
   end

   // send request words in bursts with random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (gap_left != 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_req.size() != 0) begin
            req_data <= pending_req.pop_front();
            req_valid <= 1'b1;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 80);
            end else begin
               burst_left--;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // stall the response channel on runs of its own
   always @(negedge clock) begin
      if (stall_left != 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (open_left != 0) begin
         open_left--;
         rsp_stall <= 1'b0;
      end else begin
         stall_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 50);
         open_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 400)
                                                 : $urandom_range(1, 30);
         rsp_stall <= 1'b0;
      end
   end

   task automatic queue_word(input logic [OP_WIDTH-1:0] op, input logic [KEY_WIDTH-1:0] key);
      req_type r;
      r.op = op;
      r.key = key;
      pending_req.push_back(r);
      words_queued++;
   endtask

   task automatic wait_idle();
      @(negedge clock);
      while (words_taken != words_queued || expected_rsp.size() != 0) @(negedge clock);
   endtask

   task automatic write_table_size(input int unsigned v);
      wait_idle();
      csr_valid <= 1'b1;
      csr_data <= CFG_WIDTH'(v);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [KEY_WIDTH-1:0] fresh_key(input int unsigned span);
      case ($urandom_range(0, 2))
         0: return KEY_WIDTH'($urandom_range(0, 4 * span));
         1: return KEY_WIDTH'(span * $urandom_range(0, 2000) + $urandom_range(0, 3));
         default: return KEY_WIDTH'($urandom());
      endcase
   endfunction

   initial begin
      int unsigned phase_sizes[] = '{2, 1, 3, 5, 2047, 8, 16, 0, 64, 13, 1024, 4, 1000, 31, 2};
      int unsigned span;
      int unsigned pick;
      logic [OP_WIDTH-1:0] op;
      logic [KEY_WIDTH-1:0] key;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // table at its reset size: collisions, wrap, early stop at a freed slot
      queue_word(OP_INSERT, 31'd0);
      queue_word(OP_INSERT, 31'd1024);
      queue_word(OP_INSERT, 31'h7FFFFFFF);
      queue_word(OP_INSERT, 31'd2047);
      queue_word(OP_INSERT, 31'd0);
      queue_word(OP_SEARCH, 31'd1024);
      queue_word(OP_DELETE, 31'd0);
      queue_word(OP_SEARCH, 31'd1024);
      queue_word(OP_DELETE, 31'd5);
      queue_word(OP_UNUSED, 31'd2047);
      queue_word(OP_SEARCH, 31'd2047);
      queue_word(OP_SEARCH, 31'h7FFFFFFF);
      queue_word(OP_INSERT, 31'h2AAAAAAA);
      queue_word(OP_INSERT, 31'h55555555);

      // single slot: full lap on insert and search
      write_table_size(1);
      queue_word(OP_INSERT, 31'd3);
      queue_word(OP_INSERT, 31'd8);
      queue_word(OP_SEARCH, 31'd8);
      queue_word(OP_INSERT, 31'd3);
      queue_word(OP_DELETE, 31'd8);

      // zero size acts as one slot
      write_table_size(0);
      queue_word(OP_SEARCH, 31'd3);
      queue_word(OP_DELETE, 31'd3);
      queue_word(OP_INSERT, 31'h7FFFFFFF);

      foreach (phase_sizes[p]) begin
         write_table_size(phase_sizes[p]);
         span = clamp_size(phase_sizes[p]);
         key_pool.delete();
         repeat ((span < 16) ? 2 * span + 2 : 24) begin
            key = fresh_key(span);
            key_pool.push_back(key);
            key_history.push_back(key);
         end
         for (int k = 0; k < PHASE_WORDS; k++) begin
            if (k == PHASE_WORDS / 2 && p % 3 == 0) wait_idle();
            pick = $urandom_range(0, 99);
            if (pick < 45) op = OP_INSERT;
            else if (pick < 65) op = OP_DELETE;
            else if (pick < 95) op = OP_SEARCH;
            else op = OP_UNUSED;
            pick = $urandom_range(0, 99);
            if (pick < 80) key = key_pool[$urandom_range(0, key_pool.size() - 1)];
            else if (pick < 85) key = key_history[$urandom_range(0, key_history.size() - 1)];
            else key = fresh_key(span);
            queue_word(op, key);
         end
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      repeat (TIMEOUT_CYCLES) @(posedge clock);
      $display("simulation failed");
      $finish;
   end

endmodule

[linear_probe_hash_table.f]
src/lph_pkg.sv
src/lph_mod.sv
src/linear_probe_hash_table.sv
sim/tb_linear_probe_hash_table.sv
